// File: hw/rtl/mkjp_pkg.sv
package mkjp_pkg;

   localparam int MAX_JUMP    = 8;
   localparam int HEIGHT_BITS = 16;

   // field widths fixed by the port list
   localparam int REQ_HGT_W = 16;
   localparam int COST_W    = 32;
   localparam int CFG_W     = 4;

   // window height width: low HEIGHT_BITS bits of the incoming height
   localparam int HGT_W = (HEIGHT_BITS < REQ_HGT_W) ? HEIGHT_BITS : REQ_HGT_W;
   localparam int CNT_W = $clog2(MAX_JUMP + 1);
   localparam int SUM_W = COST_W + 1;

   typedef logic [HGT_W-1:0]  hgt_type;
   typedef logic [COST_W-1:0] cost_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [SUM_W-1:0]  sum_type;
   typedef logic [CFG_W-1:0]  cfg_type;

   // one processed word, from the top level to the window
   typedef struct packed {
      logic load;
      logic path_start;
      logic path_end;
   } step_type;

endpackage

// File: hw/rtl/min_cost_k_jump_path_core.sv
// A word accepted into the input register moves to the result register and
// shows on rsp_*. Throughput: one word per cycle while rsp_stall is low; the
// min over the jump window is one combinational pass between those registers.
// Stalls hold both; a new word is taken while a result waits if in_valid_ff is low.
// Reset: synchronous, clears valids, window fill count and sets max_jump to 1.
module min_cost_k_jump_path_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_height,
   input  logic        req_path_start,
   input  logic        req_path_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_cost,
   output logic        rsp_final_res,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_max_jump
);

   mkjp_pkg::cfg_type  max_jump_ff;
   logic               in_valid_ff;
   logic               in_valid_in;
   mkjp_pkg::hgt_type  in_height_ff;
   logic               in_start_ff;
   logic               in_end_ff;
   logic               out_valid_ff;
   logic               out_valid_in;
   mkjp_pkg::cost_type out_cost_ff;
   logic               out_final_ff;
   logic               accept;
   logic               advance;
   mkjp_pkg::step_type step;
   mkjp_pkg::hgt_type  height_win [mkjp_pkg::MAX_JUMP];
   mkjp_pkg::cost_type cost_win [mkjp_pkg::MAX_JUMP];
   mkjp_pkg::cnt_type  seen_eff;
   mkjp_pkg::cost_type best_cost;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_jump_ff <= mkjp_pkg::cfg_type'(1);
      end else if (csr_valid && csr_ready) begin
         max_jump_ff <= csr_max_jump;
      end
   end

   // the held word moves on when the result register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_height_ff <= req_height[mkjp_pkg::HGT_W-1:0];
         in_start_ff  <= req_path_start;
         in_end_ff    <= req_path_end;
      end
      if (advance) begin
         out_cost_ff  <= best_cost;
         out_final_ff <= in_end_ff;
      end
   end

   assign step.load       = advance;
   assign step.path_start = in_start_ff;
   assign step.path_end   = in_end_ff;

   mkjp_window u_window (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .new_height (in_height_ff),
      .new_cost   (best_cost),
      .height_win (height_win),
      .cost_win   (cost_win),
      .seen_eff   (seen_eff)
   );

   mkjp_best u_best (
      .height     (in_height_ff),
      .max_jump   (max_jump_ff),
      .seen_eff   (seen_eff),
      .height_win (height_win),
      .cost_win   (cost_win),
      .best_cost  (best_cost)
   );

   assign rsp_valid     = out_valid_ff;
   assign rsp_cost      = out_cost_ff;
   assign rsp_final_res = out_final_ff;

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("input stalled without a blocked result");

   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      advance && in_start_ff |=> rsp_valid && rsp_cost == '0)
      else $error("path start word gave nonzero cost");

   a_final_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_final_res == $past(in_end_ff))
      else $error("final flag does not match path end");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall && in_valid_ff |=> in_valid_ff)
      else $error("held word dropped while result stalled");

endmodule

// File: hw/rtl/mkjp_window.sv
module mkjp_window (
   input  logic                 clock,
   input  logic                 reset,
   input  mkjp_pkg::step_type   step,
   input  mkjp_pkg::hgt_type    new_height,
   input  mkjp_pkg::cost_type   new_cost,
   output mkjp_pkg::hgt_type    height_win [mkjp_pkg::MAX_JUMP],
   output mkjp_pkg::cost_type   cost_win [mkjp_pkg::MAX_JUMP],
   output mkjp_pkg::cnt_type    seen_eff
);

   mkjp_pkg::hgt_type  hgt_ff  [mkjp_pkg::MAX_JUMP];
   mkjp_pkg::cost_type cost_ff [mkjp_pkg::MAX_JUMP];
   mkjp_pkg::cnt_type  seen_ff;
   mkjp_pkg::cnt_type  seen_in;
   logic               ended_ff;
   logic               restart;

   // a new path begins on a start flag or right after a path end
   assign restart  = step.path_start || ended_ff;
   assign seen_eff = restart ? '0 : seen_ff;

   always_comb begin
      if (32'(seen_eff) < mkjp_pkg::MAX_JUMP) begin
         seen_in = seen_eff + mkjp_pkg::cnt_type'(1);
      end else begin
         seen_in = seen_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= '0;
         ended_ff <= 1'b0;
      end else if (step.load) begin
         seen_ff  <= seen_in;
         ended_ff <= step.path_end;
      end
   end

   // entries beyond seen_ff are masked downstream, so no reset needed here
   always_ff @(posedge clock) begin
      if (step.load) begin
         hgt_ff[0]  <= new_height;
         cost_ff[0] <= new_cost;
         for (int j = 1; j < mkjp_pkg::MAX_JUMP; j++) begin
            hgt_ff[j]  <= hgt_ff[j-1];
            cost_ff[j] <= cost_ff[j-1];
         end
      end
   end

   assign height_win = hgt_ff;
   assign cost_win   = cost_ff;

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      32'(seen_ff) <= mkjp_pkg::MAX_JUMP)
      else $error("seen count above window depth");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      step.load && restart |=> seen_ff == mkjp_pkg::cnt_type'(1))
      else $error("restart did not leave one valid entry");

endmodule

// File: hw/rtl/mkjp_best.sv
module mkjp_best (
   input  mkjp_pkg::hgt_type    height,
   input  mkjp_pkg::cfg_type    max_jump,
   input  mkjp_pkg::cnt_type    seen_eff,
   input  mkjp_pkg::hgt_type    height_win [mkjp_pkg::MAX_JUMP],
   input  mkjp_pkg::cost_type   cost_win [mkjp_pkg::MAX_JUMP],
   output mkjp_pkg::cost_type   best_cost
);

   localparam int LVLS   = $clog2(mkjp_pkg::MAX_JUMP);
   localparam int LEAVES = 1 << LVLS;
   localparam int NODES  = 2 * LEAVES - 1;

   logic [31:0]       lim_cfg;
   logic [31:0]       lim;
   mkjp_pkg::hgt_type diff;
   mkjp_pkg::sum_type tree [NODES];
   mkjp_pkg::sum_type top;

   // effective jump limit: config clamped to 1..window, then at most seen
   always_comb begin
      lim_cfg = 32'(max_jump);
      if (lim_cfg < 32'd1) begin
         lim_cfg = 32'd1;
      end
      if (lim_cfg > mkjp_pkg::MAX_JUMP) begin
         lim_cfg = mkjp_pkg::MAX_JUMP;
      end
      lim = (lim_cfg > 32'(seen_eff)) ? 32'(seen_eff) : lim_cfg;
   end

   // candidates at the leaves, masked ones at all ones, then a min tree
   always_comb begin
      diff = '0;
      for (int i = 0; i < NODES; i++) begin
         tree[i] = '1;
      end
      for (int j = 0; j < mkjp_pkg::MAX_JUMP; j++) begin
         diff = (height >= height_win[j]) ? height - height_win[j]
                                          : height_win[j] - height;
         if (32'(j) < lim) begin
            tree[LEAVES-1+j] = mkjp_pkg::sum_type'(cost_win[j])
                             + mkjp_pkg::sum_type'(diff);
         end
      end
      for (int i = LEAVES - 2; i >= 0; i--) begin
         tree[i] = (tree[2*i+1] < tree[2*i+2]) ? tree[2*i+1] : tree[2*i+2];
      end
      top = tree[0];
   end

   always_comb begin
      if (lim == 32'd0) begin
         best_cost = '0;
      end else if (top[mkjp_pkg::COST_W]) begin
         best_cost = '1;
      end else begin
         best_cost = top[mkjp_pkg::COST_W-1:0];
      end
   end

endmodule
